/* rtl/assert_macros.svh */
// Assertion macros shared by the divider RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge, disabled while reset is low.
`define SIDU_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define SIDU_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`else

`define SIDU_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define SIDU_NEVER(lbl, clk_s, rstn_s, cond, msg)

`endif

`endif

/* rtl/sidu_pkg.sv */
// Shared types and constants for the signed integer divider.
// No dependencies; imported by the step stage and the top level.
`timescale 1ns / 1ps

package sidu_pkg;

  // Operand and result width
  localparam int unsigned DIV_W = 32;

  // Most negative operand value
  localparam logic [DIV_W-1:0] MIN_VAL = {1'b1, {(DIV_W-1){1'b0}}};

  // Input transfer payload
  typedef struct packed {
    logic signed [DIV_W-1:0] dividend;
    logic signed [DIV_W-1:0] divisor;
    logic                    want_quotient;
  } div_in_t;

  // Output transfer payload
  typedef struct packed {
    logic signed [DIV_W-1:0] answer;
    logic                    div_by_zero;
    logic                    overflowed;
  } div_out_t;

  // State carried down the pipeline for one operation
  typedef struct packed {
    logic [DIV_W-1:0] rem;     // partial remainder
    logic [DIV_W-1:0] quo;     // dividend bits shifting out, quotient bits shifting in
    logic [DIV_W-1:0] mb;      // divisor magnitude
    logic             neg_q;   // quotient must be negated
    logic             neg_r;   // remainder must be negated
    logic             sel_q;   // return quotient
    logic             dz;      // zero divisor
    logic             ov;      // minimum value over minus one
  } stage_t;

endpackage

/* rtl/sidu_step.sv */
// One restoring-division step: produces one quotient bit per stage.
// Depends on sidu_pkg for the stage state type.
`timescale 1ns / 1ps

module sidu_step (
  input  sidu_pkg::stage_t cur,
  output sidu_pkg::stage_t nxt
);
  import sidu_pkg::*;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           qbit;

  // Shift next dividend bit into the partial remainder and try to subtract
  assign trial = {cur.rem, cur.quo[DIV_W-1]};
  assign diff  = trial - {1'b0, cur.mb};
  assign qbit  = ~diff[DIV_W];

  always_comb begin
    nxt     = cur;
    nxt.rem = qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    nxt.quo = {cur.quo[DIV_W-2:0], qbit};
  end

endmodule

/* rtl/signed_integer_divider_unit.sv */
// Signed integer divider, fully pipelined, one quotient bit per stage.
// Depends on sidu_pkg, sidu_step and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
//  - Input channel in_valid / in_stall / in_data carries dividend, divisor and
//    want_quotient. A transfer happens when in_valid is high and in_stall low.
//  - Output channel out_valid / out_stall / out_data returns the quotient
//    (truncated toward zero) or the remainder (sign of the dividend), plus the
//    div_by_zero and overflowed flags. A zero divisor returns 0.
//  - Operand magnitudes are registered in the head stage, each quotient bit
//    in its own step stage of the chain, and the sign-corrected result in
//    the output register.
//  - Throughput is one operation per cycle unless out_stall freezes the
//    pipeline; each step stage holds one subtract-and-compare of DIV_W + 1 bits.
//  - While the output register holds a result and out_stall is high, the
//    whole pipeline freezes and in_stall is raised; nothing is dropped or
//    repeated, and transfers resume the cycle out_stall falls.
//  - Synchronous active-low reset empties the pipeline; the first transfer
//    may be offered in the cycle after reset is released.

module signed_integer_divider_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sidu_pkg::div_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sidu_pkg::div_out_t out_data
);
  import sidu_pkg::*;

  localparam int unsigned NSTG = DIV_W + 1;

  logic             adv;
  logic [NSTG-1:0]  vld_r;
  stage_t           pipe_r [NSTG];
  stage_t           step_nxt [DIV_W];
  stage_t           head_nxt;
  logic             out_valid_r;
  div_out_t         out_r;
  div_out_t         out_nxt;

  logic [DIV_W-1:0] a_u;
  logic [DIV_W-1:0] b_u;
  logic             na;
  logic             nb;
  logic [DIV_W-1:0] q_fix;
  logic [DIV_W-1:0] r_fix;

  // Pipeline moves whenever the output register is free or being drained
  assign adv      = ~(out_valid_r & out_stall);
  assign in_stall = ~adv;

  // Head stage: operand magnitudes and special-case flags
  assign a_u = in_data.dividend;
  assign b_u = in_data.divisor;
  assign na  = a_u[DIV_W-1];
  assign nb  = b_u[DIV_W-1];

  always_comb begin
    head_nxt.rem   = '0;
    head_nxt.quo   = na ? (~a_u + DIV_W'(1)) : a_u;
    head_nxt.mb    = nb ? (~b_u + DIV_W'(1)) : b_u;
    head_nxt.neg_q = na ^ nb;
    head_nxt.neg_r = na;
    head_nxt.sel_q = in_data.want_quotient;
    head_nxt.dz    = (b_u == '0);
    head_nxt.ov    = (a_u == MIN_VAL) && (b_u == '1);
  end

  // Step chain, one quotient bit per stage
  genvar gi;
  generate
    for (gi = 0; gi < DIV_W; gi++) begin : g_step
      sidu_step u_step (
        .cur (pipe_r[gi]),
        .nxt (step_nxt[gi])
      );
    end
  endgenerate

  // Stage payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r[0] <= head_nxt;
      for (int k = 0; k < DIV_W; k++) begin
        pipe_r[k+1] <= step_nxt[k];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // Sign correction and result select
  assign q_fix = pipe_r[NSTG-1].neg_q ? (~pipe_r[NSTG-1].quo + DIV_W'(1))
                                      : pipe_r[NSTG-1].quo;
  assign r_fix = pipe_r[NSTG-1].neg_r ? (~pipe_r[NSTG-1].rem + DIV_W'(1))
                                      : pipe_r[NSTG-1].rem;

  always_comb begin
    out_nxt.div_by_zero = pipe_r[NSTG-1].dz;
    out_nxt.overflowed  = pipe_r[NSTG-1].ov;
    if (pipe_r[NSTG-1].dz) begin
      out_nxt.answer = '0;
    end else if (pipe_r[NSTG-1].sel_q) begin
      out_nxt.answer = q_fix;
    end else begin
      out_nxt.answer = r_fix;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  `SIDU_ASSERT(a_dz_zero, clk, rst_n,
    (out_valid_r && out_r.div_by_zero) |-> (out_r.answer == '0),
    "zero divisor must give zero answer")
  `SIDU_NEVER(a_flags_excl, clk, rst_n,
    out_valid_r && out_r.div_by_zero && out_r.overflowed,
    "div_by_zero and overflowed both set")
  `SIDU_ASSERT(a_ov_value, clk, rst_n,
    (out_valid_r && out_r.overflowed) |-> ((out_r.answer == MIN_VAL) || (out_r.answer == '0)),
    "overflow answer must be minimum value or zero")
  `SIDU_ASSERT(a_frozen, clk, rst_n,
    (out_valid_r && out_stall) |=> (vld_r == $past(vld_r)),
    "pipeline moved while output stalled")

endmodule
